// File: sv/stack_vm_instruction_executor_unit_assert.svh
// Assertion macros for the stack VM executor.
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define SVM_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SVM_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: sv/svm_pkg.sv
// Package: opcodes, faults, states and defaults for the stack VM executor.
package svm_pkg;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int IP_BITS_DEF = 16;
  localparam int CALL_NEST_DEF = 16;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_POP = 5'd1, OP_MOV = 5'd2, OP_PUSH_SF = 5'd3, OP_POP_SF = 5'd4,
    OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_BW_OR = 5'd9,
    OP_BW_AND = 5'd10, OP_OR = 5'd11, OP_AND = 5'd12, OP_LT = 5'd13, OP_GT = 5'd14,
    OP_GTE = 5'd15, OP_LTE = 5'd16, OP_EQL = 5'd17, OP_JMP = 5'd18,
    OP_JMP_ZERO = 5'd19, OP_HLT = 5'd20
  } opcode_t;

  localparam logic [2:0] F_OK = 3'd0;
  localparam logic [2:0] F_UNDER = 3'd1;
  localparam logic [2:0] F_OVER = 3'd2;
  localparam logic [2:0] F_DIV0 = 3'd3;
  localparam logic [2:0] F_UNKNOWN = 3'd4;
  localparam logic [2:0] F_SLOT = 3'd5;

  localparam logic [1:0] K_LIT = 2'd0;
  localparam logic [1:0] K_FRAME = 2'd1;
  localparam logic [1:0] K_ABS = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_RSV1, S_RSV2, S_OPND, S_EXEC, S_DIV, S_WB, S_TOP, S_TOPW, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic        is_signed_div;
  } div_ctl_t;
endpackage

// File: sv/svm_if.sv
// Valid/ready channel interfaces for instructions and results.
interface svm_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  opcode;
  logic [1:0]  value_kind;
  logic signed [31:0] operand;
  modport source(output valid, opcode, value_kind, operand, input ready);
  modport sink(input valid, opcode, value_kind, operand, output ready);
endinterface

interface svm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_ip;
  logic [1:0]  top_kind;
  logic signed [31:0] top_value;
  logic [8:0]  stack_depth;
  logic [8:0]  frame_base_out;
  logic        halted;
  logic [2:0]  fault;
  modport source(output valid, next_ip, top_kind, top_value, stack_depth, frame_base_out,
                 halted, fault, input ready);
  modport sink(input valid, next_ip, top_kind, top_value, stack_depth, frame_base_out,
               halted, fault, output ready);
endinterface

// File: sv/stack_vm_instruction_executor_unit.sv
// Top level: sequenced stack VM instruction executor.
// Channel | dir | handshake   | payload
// in_     | in  | valid/ready | opcode, value_kind, operand
// out_    | out | valid/ready | next_ip, top_kind, top_value, depth, base, halted, fault
// One instruction at a time: each is accepted in IDLE, decoded in EXEC, and its result
// offered in OUT after the top of stack is read (TOP, TOPW); a fault found at decode skips
// to TOP. PUSH/POP/HLT write back in WB; a binary op first pops (RD1, RD2) and resolves
// its operands (RSV1, RSV2, OPND), and DIV waits in DIV for the divider. The value stack
// memory has one read and one write port. Reset is synchronous, active low; the stack
// memory is not cleared. in_ready is low from acceptance until the result is taken.
module stack_vm_instruction_executor_unit #(
  parameter int STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF,
  parameter int IP_BITS = svm_pkg::IP_BITS_DEF,
  parameter int CALL_NEST = svm_pkg::CALL_NEST_DEF
) (
  input logic clk,
  input logic rst_n,
  svm_in_if.sink in_ch,
  svm_out_if.source out_ch
);
  import svm_pkg::*;
  `include "stack_vm_instruction_executor_unit_assert.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int PAW = (CALL_NEST > 1) ? $clog2(CALL_NEST) : 1;
  localparam int PCW = $clog2(CALL_NEST + 1);

  logic [33:0] mem [STACK_DEPTH];
  logic [CW-1:0] pend [CALL_NEST];

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, base_r, base_nxt;
  logic [IP_BITS-1:0] ip_r, ip_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic [4:0]  op_r;
  logic [1:0]  kind_r;
  logic [31:0] opnd_r;
  logic [33:0] e1_r, e2_r, rd_data;
  logic [31:0] v1_r, v2_r, v2_op;
  logic [2:0]  fault_r, fault_nxt;
  logic        halted_r;
  logic [1:0]  tk_r;
  logic [31:0] tv_r;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [33:0] wdata;
  div_ctl_t    dctl;
  logic        ddone;
  logic [31:0] dq;
  logic [63:0] idx;
  logic        idx_ok;
  logic [31:0] alu;
  logic [AW-1:0] idx_r_addr;

  assign v2_op = (e2_r[33:32] == K_LIT) ? e2_r[31:0] : rd_data[31:0];

  svm_div u_div (.clk, .rst_n, .ctl(dctl), .dividend(v2_op), .divisor(v1_r),
                 .done(ddone), .quotient(dq));

  // shared slot index/bounds unit
  always_comb begin
    logic [63:0] src, lim;
    src = {{32{opnd_r[31]}}, opnd_r};
    lim = 64'(cnt_r);
    idx = src + 64'(base_r);
    case (state_r)
      S_RSV1: begin
        idx = {{32{e1_r[31]}}, e1_r[31:0]} + 64'(base_r);
        lim = 64'(cnt_r) - 64'd2;
      end
      S_RSV2: begin
        idx = {{32{e2_r[31]}}, e2_r[31:0]} + 64'(base_r);
        lim = 64'(cnt_r) - 64'd2;
      end
      S_RD1: begin
        if (op_r == OP_MOV) lim = 64'(cnt_r) - 64'd1;
        if (op_r == OP_JMP && kind_r == K_ABS) idx = src;
      end
      default: ;
    endcase
    idx_ok = !idx[63] && (idx < lim);
  end

  always_comb begin
    alu = '0;
    case (op_r)
      OP_ADD: alu = v2_r + v1_r;
      OP_SUB: alu = v2_r - v1_r;
      OP_MUL: alu = v2_r * v1_r;
      OP_BW_OR: alu = v2_r | v1_r;
      OP_BW_AND: alu = v2_r & v1_r;
      OP_OR: alu = 32'((v2_r != 0) || (v1_r != 0));
      OP_AND: alu = 32'((v2_r != 0) && (v1_r != 0));
      OP_LT: alu = 32'($signed(v2_r) < $signed(v1_r));
      OP_GT: alu = 32'($signed(v2_r) > $signed(v1_r));
      OP_GTE: alu = 32'($signed(v2_r) >= $signed(v1_r));
      OP_LTE: alu = 32'($signed(v2_r) <= $signed(v1_r));
      default: alu = 32'(v2_r == v1_r);
    endcase
  end

  // next state
  always_comb begin
    logic binop;
    binop = op_r >= OP_ADD && op_r <= OP_EQL;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (fault_nxt != F_OK) state_nxt = S_TOP;
        else if (op_r == OP_POP_SF || binop || op_r == OP_JMP_ZERO || op_r == OP_MOV
                 || (op_r == OP_JMP && kind_r != K_LIT && kind_r != 2'd3))
          state_nxt = S_RD1;
        else state_nxt = S_WB;
      end
      S_RD1: begin
        if (op_r == OP_MOV || op_r == OP_JMP) state_nxt = idx_ok ? S_WB : S_TOP;
        else if (op_r == OP_JMP_ZERO) state_nxt = S_WB;
        else state_nxt = S_RD2;
      end
      S_RD2: state_nxt = (op_r == OP_POP_SF) ? S_WB : S_RSV1;
      S_RSV1: state_nxt = (e1_r[33:32] == K_LIT || idx_ok) ? S_RSV2 : S_TOP;
      S_RSV2: state_nxt = (e2_r[33:32] == K_LIT || idx_ok) ? S_OPND : S_TOP;
      S_OPND: state_nxt = (op_r == OP_DIV) ? S_DIV : S_WB;
      S_DIV: if (ddone) state_nxt = S_WB;
      S_WB: state_nxt = S_TOP;
      S_TOP: state_nxt = S_TOPW;
      S_TOPW: state_nxt = S_OUT;
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    logic [31:0] pbv;
    cnt_nxt = cnt_r;
    base_nxt = base_r;
    ip_nxt = ip_r;
    pcnt_nxt = pcnt_r;
    fault_nxt = fault_r;
    raddr = cnt_r[AW-1:0] - AW'(1);
    we = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = {kind_r, opnd_r};
    dctl = '{start: 1'b0, is_signed_div: 1'b1};
    pbv = e1_r[31:0];
    case (state_r)
      S_EXEC: begin
        ip_nxt = ip_r + IP_BITS'(1);
        fault_nxt = F_OK;
        case (op_r)
          OP_PUSH: if (cnt_r >= CW'(STACK_DEPTH)) fault_nxt = F_OVER;
          OP_POP, OP_MOV, OP_JMP_ZERO: if (cnt_r == '0) fault_nxt = F_UNDER;
          OP_PUSH_SF: if (cnt_r >= CW'(STACK_DEPTH) || pcnt_r >= PCW'(CALL_NEST))
            fault_nxt = F_OVER;
          OP_JMP, OP_HLT: ;
          default: begin
            if (op_r > OP_HLT) fault_nxt = F_UNKNOWN;
            else if (cnt_r < CW'(2)) fault_nxt = F_UNDER;
          end
        endcase
      end
      S_RD1: begin
        if (op_r == OP_MOV || op_r == OP_JMP) begin
          raddr = idx[AW-1:0];
          if (!idx_ok) fault_nxt = F_SLOT;
        end
      end
      S_RD2: raddr = cnt_r[AW-1:0] - AW'(2);
      S_RSV1: begin
        raddr = idx[AW-1:0];
        if (!(e1_r[33:32] == K_LIT || idx_ok)) fault_nxt = F_SLOT;
      end
      S_RSV2: begin
        raddr = idx[AW-1:0];
        if (!(e2_r[33:32] == K_LIT || idx_ok)) fault_nxt = F_SLOT;
      end
      S_OPND: dctl.start = (op_r == OP_DIV);
      S_WB: begin
        case (op_r)
          OP_PUSH: begin
            we = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          OP_POP: cnt_nxt = cnt_r - CW'(1);
          OP_MOV: begin
            we = 1'b1;
            waddr = idx_r_addr;
            wdata = e1_r;
            cnt_nxt = cnt_r - CW'(1);
          end
          OP_PUSH_SF: begin
            we = 1'b1;
            wdata = {K_LIT, 32'(base_r)};
            cnt_nxt = cnt_r + CW'(1);
            pcnt_nxt = pcnt_r + PCW'(1);
          end
          OP_POP_SF: begin
            if ($signed(pbv) < 0 || $signed(pbv) > STACK_DEPTH) begin
              fault_nxt = F_SLOT;
            end else begin
              ip_nxt = rd_data[IP_BITS-1:0];
              base_nxt = pbv[CW-1:0];
              cnt_nxt = cnt_r - CW'(2);
            end
          end
          OP_JMP: begin
            ip_nxt = (kind_r == K_FRAME || kind_r == K_ABS) ? rd_data[IP_BITS-1:0]
                                                              : opnd_r[IP_BITS-1:0];
            if (pcnt_r != '0) begin
              base_nxt = pend[PAW'(pcnt_r - PCW'(1))];
              pcnt_nxt = pcnt_r - PCW'(1);
            end
          end
          OP_JMP_ZERO: begin
            cnt_nxt = cnt_r - CW'(1);
            if (e1_r[31:0] == '0) ip_nxt = opnd_r[IP_BITS-1:0];
          end
          OP_HLT: ;
          default: begin
            we = 1'b1;
            waddr = cnt_r[AW-1:0] - AW'(2);
            cnt_nxt = cnt_r - CW'(1);
            if (op_r == OP_DIV) begin
              wdata = {K_LIT, (v1_r == '0) ? 32'd0 : dq};
              if (v1_r == '0) fault_nxt = F_DIV0;
            end else wdata = {K_LIT, alu};
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD1) idx_r_addr <= idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[raddr];
    if (we) mem[waddr] <= wdata;
    if (state_r == S_WB && op_r == OP_PUSH_SF && fault_nxt == F_OK)
      pend[PAW'(pcnt_r)] <= cnt_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      base_r <= '0;
      ip_r <= '0;
      pcnt_r <= '0;
      fault_r <= F_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      base_r <= base_nxt;
      ip_r <= ip_nxt;
      pcnt_r <= pcnt_nxt;
      fault_r <= fault_nxt;
    end
    if (state_r == S_IDLE && in_ch.valid) begin
      op_r <= in_ch.opcode;
      kind_r <= in_ch.value_kind;
      opnd_r <= in_ch.operand;
      halted_r <= in_ch.opcode == OP_HLT;
    end
    // read data is registered and lands in the cycle after its address
    if (state_r == S_RD1) e1_r <= rd_data;
    if (state_r == S_RSV1) e2_r <= rd_data;
    if (state_r == S_RSV2) v1_r <= (e1_r[33:32] == K_LIT) ? e1_r[31:0] : rd_data[31:0];
    if (state_r == S_OPND) v2_r <= v2_op;
    if (state_r == S_TOPW) begin
      tk_r <= (cnt_r == '0) ? 2'd0 : rd_data[33:32];
      tv_r <= (cnt_r == '0) ? 32'd0 : rd_data[31:0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.next_ip = 16'(ip_r);
  assign out_ch.top_kind = tk_r;
  assign out_ch.top_value = tv_r;
  assign out_ch.stack_depth = 9'(cnt_r);
  assign out_ch.frame_base_out = 9'(base_r);
  assign out_ch.halted = halted_r;
  assign out_ch.fault = fault_r;

  `SVM_ASSERT_IMPL(a_busy_not_ready, state_r != S_IDLE, !in_ch.ready)
  `SVM_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(cnt_r))
  `SVM_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CW'(STACK_DEPTH))
endmodule

// File: sv/svm_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
module svm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  svm_pkg::div_ctl_t  ctl,
  input  logic [31:0]        dividend,
  input  logic [31:0]        divisor,
  output logic               done,
  output logic [31:0]        quotient
);
  import svm_pkg::*;
  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt;
  logic [32:0] trial;
  logic [31:0] na, nb;

  always_comb begin
    na = dividend[31] ? (32'd0 - dividend) : dividend;
    nb = divisor[31] ? (32'd0 - divisor) : divisor;
    trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};
    q_nxt = q_r;
    d_nxt = d_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      q_nxt = na;
      d_nxt = nb;
      rem_nxt = '0;
      cnt_nxt = 6'd32;
      neg_nxt = ctl.is_signed_div & (dividend[31] ^ divisor[31]);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    d_r <= d_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done = !busy_r && !ctl.start;
  assign quotient = neg_r ? (32'd0 - q_r) : q_r;
endmodule
